FILE: sv/atan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan_pkg
// Shared types and Q30 constants for the phase approximation block.
// ----------------------------------------------------------------------------
package atan_pkg;

    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // internal fixed point: Q30
    localparam int QB = 30;
    localparam int RW = QB + 1;          // ratio / product magnitude width (<= 1.0)
    localparam int AW = 34;              // signed Q30 angle width

    localparam logic [31:0] Q_ONE          = 32'h4000_0000;
    localparam logic [31:0] PI_Q           = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q      = 32'd1686629713;
    localparam logic [31:0] QTR_PI_Q       = 32'd843314857;
    localparam logic [31:0] THREE_QTR_PI_Q = 32'd2529944570;
    localparam logic [31:0] K_CUBIC_A      = 32'd210775520;
    localparam logic [31:0] K_CUBIC_B      = 32'd1054092349;
    localparam logic [31:0] K_RATIO        = 32'd300647711;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    // register map
    localparam logic REG_METHOD_SELECT = 1'b0;

    typedef enum logic {
        METHOD_CUBIC    = 1'b0,
        METHOD_RATIONAL = 1'b1
    } t_method;

    // classification of one sample, travels alongside the operands
    typedef struct packed {
        t_method method;
        logic    rneg;     // cubic: r is negative
        logic    base_hi;  // cubic: base is 3pi/4
        logic    yneg;
        logic    yzero;
        logic    xneg;
        logic    xzero;
        logic    swap;     // rational: ratio is x/y
    } t_flags;

endpackage

FILE: sv/atan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan_in_if / atan_out_if
// Valid/ready channels for complex samples and phase results.
// ----------------------------------------------------------------------------
interface atan_in_if #(
    parameter int SW = 16
);
    logic          valid;
    logic          ready;
    logic [SW-1:0] y_value;
    logic [SW-1:0] x_value;

    modport source (output valid, output y_value, output x_value, input ready);
    modport sink   (input valid, input y_value, input x_value, output ready);
endinterface

interface atan_out_if #(
    parameter int PW = 16
);
    logic          valid;
    logic          ready;
    logic [PW-1:0] phase_angle;

    modport source (output valid, output phase_angle, input ready);
    modport sink   (input valid, input phase_angle, output ready);
endinterface

FILE: sv/atan2_phase_approximation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_phase_approximation_top
// Phase of a complex sample, cubic or 0.28 rational approximation.
// ----------------------------------------------------------------------------
// Usage
//   i_in  : one beat per complex sample (y_value = imaginary, x_value = real,
//           signed SAMPLE_WIDTH bits).
//   o_out : one beat per sample, phase_angle in radians, signed, with
//           ANGLE_FRAC_BITS fraction bits (pi = 25736 at the default).
//   APB   : one register at offset 0, bit 0 = method (0 cubic, 1 rational).
//           Change it only while no beat is in flight.
// Throughput: one beat per cycle, sustained while o_out is not held.
// Pipeline: an input beat passes the queue, the two bit-per-stage dividers
//   (31 stages each) and the multiply and rounding stages before it leaves
//   as an output beat.
// Reset: synchronous, active low. Clears queue, pipeline valids and puts the
//   method back to rational.
// Stall: a held output freezes the back pipeline; the four-entry queue keeps
//   taking beats until full, then i_in.ready drops.
// ----------------------------------------------------------------------------
module atan2_phase_approximation_top #(
    parameter int SAMPLE_WIDTH    = atan_pkg::SAMPLE_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = atan_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    atan_in_if.sink        i_in,
    atan_out_if.source     o_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import atan_pkg::*;

    // operand magnitudes carry two bits above the sample; |x| + |y| needs one
    localparam int OW = SAMPLE_WIDTH + 2;
    localparam int PW = ANGLE_FRAC_BITS + 3;
    localparam int S  = QB - ANGLE_FRAC_BITS;
    localparam logic signed [PW:0] LIM =
        $signed((PW+1)'((64'(PI_Q) + (64'(1) << (S - 1))) >> S) + (PW+1)'(1));

    t_method         r_method;
    logic            w_head_valid, w_pop;
    logic [OW-1:0]   w_head_a, w_head_b;
    t_flags          w_head_flags;

    // configuration: written on the access phase
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= METHOD_RATIONAL;
        end else if (psel && penable && pwrite && (paddr[2] == REG_METHOD_SELECT)) begin
            r_method <= t_method'(pwdata[0]);
        end
    end

    assign prdata = (paddr[2] == REG_METHOD_SELECT) ? {31'b0, r_method} : '0;

    // front: classify and queue
    atan_front #(.SW(SAMPLE_WIDTH), .OW(OW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_method     (r_method),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_y          (i_in.y_value),
        .i_x          (i_in.x_value),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head_a     (w_head_a),
        .o_head_b     (w_head_b),
        .o_head_flags (w_head_flags)
    );

    // back: divide, evaluate, fix quadrant, round
    atan_back #(.OW(OW), .AFB(ANGLE_FRAC_BITS), .PW(PW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head_a     (w_head_a),
        .i_head_b     (w_head_b),
        .i_head_flags (w_head_flags),
        .o_pop        (w_pop),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_phase      (o_out.phase_angle)
    );

    // result never strays past pi (one LSB of slack for the cubic corner)
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (($signed({o_out.phase_angle[PW-1], o_out.phase_angle}) <= LIM) &&
                         ($signed({o_out.phase_angle[PW-1], o_out.phase_angle}) >= -LIM)))
        else $error("phase beyond pi");

    // nothing is offered straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk) $rose(i_rst_n) |-> !o_out.valid)
        else $error("output valid out of reset");

    // a queued beat is taken whenever the back end advances
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.ready && w_head_valid) |-> w_pop)
        else $error("back end stalled with free output");

endmodule

FILE: sv/atan_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan_front
// Accepts samples, works out operands and flags, and queues them.
// ----------------------------------------------------------------------------
module atan_front #(
    parameter int SW = 16,
    parameter int OW = SW + 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  atan_pkg::t_method   i_method,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SW-1:0]       i_y,
    input  logic [SW-1:0]       i_x,
    input  logic                i_pop,
    output logic                o_head_valid,
    output logic [OW-1:0]       o_head_a,
    output logic [OW-1:0]       o_head_b,
    output atan_pkg::t_flags    o_head_flags
);
    import atan_pkg::*;

    logic signed [SW:0] w_ys, w_xs;
    logic [OW-1:0]      w_ay, w_ax, w_a, w_b;
    t_flags             w_fl;
    logic               w_push, w_pop;

    logic [OW-1:0]      r_a  [QDEPTH];
    logic [OW-1:0]      r_b  [QDEPTH];
    t_flags             r_fl [QDEPTH];
    logic [QPW-1:0]     r_wp, r_rp;
    logic [QPW:0]       r_cnt;

    always_comb begin
        w_ys = $signed({i_y[SW-1], i_y});
        w_xs = $signed({i_x[SW-1], i_x});
        w_ay = OW'(unsigned'(w_ys[SW] ? -w_ys : w_ys));
        w_ax = OW'(unsigned'(w_xs[SW] ? -w_xs : w_xs));

        w_fl         = '0;
        w_fl.method  = i_method;
        w_fl.yneg    = i_y[SW-1];
        w_fl.xneg    = i_x[SW-1];
        w_fl.yzero   = (i_y == '0);
        w_fl.xzero   = (i_x == '0);
        w_fl.base_hi = i_x[SW-1];
        w_fl.swap    = !(w_ay < w_ax);

        if (i_method == METHOD_CUBIC) begin
            w_b = w_ax + w_ay;
            w_a = (w_ax < w_ay) ? (w_ay - w_ax) : (w_ax - w_ay);
            w_fl.rneg = i_x[SW-1] ? (w_ay < w_ax) : (w_ax < w_ay);
            if (w_b == '0) begin
                // both parts zero: r = -1
                w_a       = OW'(1);
                w_b       = OW'(1);
                w_fl.rneg = 1'b1;
            end
        end else begin
            w_a = w_fl.swap ? w_ax : w_ay;
            w_b = w_fl.swap ? w_ay : w_ax;
            if (w_fl.xzero) begin
                w_a = '0;
                w_b = OW'(1);
            end
        end
    end

    assign o_ready      = (r_cnt != (QPW+1)'(QDEPTH));
    assign w_push       = i_valid && o_ready;
    assign o_head_valid = (r_cnt != '0);
    assign w_pop        = i_pop && o_head_valid;
    assign o_head_a     = r_a[r_rp];
    assign o_head_b     = r_b[r_rp];
    assign o_head_flags = r_fl[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPW+1)'(w_push) - (QPW+1)'(w_pop);
        end
        if (w_push) begin
            r_a[r_wp]  <= w_a;
            r_b[r_wp]  <= w_b;
            r_fl[r_wp] <= w_fl;
        end
    end

endmodule

FILE: sv/atan_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module atan_div #(
    parameter int NW  = 48,
    parameter int DW  = 18,
    parameter int QW  = 31,
    parameter int SBW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [NW-1:0]   i_num,
    input  logic [DW-1:0]   i_den,
    input  logic [SBW-1:0]  i_sb,
    output logic            o_valid,
    output logic [QW-1:0]   o_quot,
    output logic [SBW-1:0]  o_sb
);
    // quotient must be below 2**QW; caller guarantees it

    logic [NW-1:0]  r_rem [QW];
    logic [DW-1:0]  r_d   [QW];
    logic [QW-1:0]  r_q   [QW];
    logic [SBW-1:0] r_sb  [QW];
    logic [QW-1:0]  r_v;

    logic [NW-1:0]  w_rem [QW];
    logic [DW-1:0]  w_d   [QW];
    logic [QW-1:0]  w_q   [QW];
    logic [SBW-1:0] w_sb  [QW];
    logic [QW-1:0]  w_v;
    logic [NW-1:0]  w_dsh [QW];
    logic [QW-1:0]  w_ge;

    always_comb begin
        w_rem[0] = i_num;
        w_d[0]   = i_den;
        w_q[0]   = '0;
        w_sb[0]  = i_sb;
        w_v[0]   = i_valid;
        for (int k = 1; k < QW; k++) begin
            w_rem[k] = r_rem[k-1];
            w_d[k]   = r_d[k-1];
            w_q[k]   = r_q[k-1];
            w_sb[k]  = r_sb[k-1];
            w_v[k]   = r_v[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            w_dsh[k] = NW'(w_d[k]) << (QW - 1 - k);
            w_ge[k]  = (w_rem[k] >= w_dsh[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= w_v;
        end
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= w_ge[k] ? (w_rem[k] - w_dsh[k]) : w_rem[k];
                r_d[k]   <= w_d[k];
                r_q[k]   <= w_q[k] | (w_ge[k] ? (QW'(1) << (QW - 1 - k)) : '0);
                r_sb[k]  <= w_sb[k];
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_sb    = r_sb[QW-1];

endmodule

FILE: sv/atan_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan_back
// Ratio divide, polynomial / rational evaluation, quadrant fix and rounding.
// ----------------------------------------------------------------------------
module atan_back #(
    parameter int OW  = 18,
    parameter int AFB = 13,
    parameter int PW  = AFB + 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_valid,
    input  logic [OW-1:0]       i_head_a,
    input  logic [OW-1:0]       i_head_b,
    input  atan_pkg::t_flags    i_head_flags,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [PW-1:0]       o_phase
);
    import atan_pkg::*;

    localparam int N1W = OW + QB + 1;
    localparam int N2W = 2 * RW;
    localparam int FW  = $bits(t_flags);
    localparam int S   = QB - AFB;
    localparam logic [AW-1:0] HALF = AW'(1) << (S - 1);

    logic              w_en;
    logic [N1W-1:0]    w_n1;
    logic              w_v1;
    logic [RW-1:0]     w_q1;
    logic [FW-1:0]     w_sb1;

    logic              r_v2, r_v3, r_v4, r_v5, r_ov;
    logic [RW-1:0]     r_q2, r_q3, r_q4, r_sq, r_m2, r_p, r_den;
    t_flags            r_f2, r_f3, r_f4;
    logic signed [AW-1:0] r_ang;
    logic [PW-1:0]     r_out;

    logic [2*RW-1:0]   w_prod_sq, w_prod_k, w_prod_p;
    logic [31:0]       w_k;
    logic [RW-1:0]     w_t;
    logic [N2W-1:0]    w_n2;

    logic              w_vd;
    logic [RW-1:0]     w_f;
    logic [FW+RW-1:0]  w_sbd;
    t_flags            w_fd;
    logic [RW-1:0]     w_pd;
    logic signed [AW-1:0] w_fs, w_base, w_ang;
    logic [AW-1:0]     w_mag, w_rnd;

    // the whole back end moves together unless the output register is held
    assign w_en  = !r_ov || i_ready;
    assign o_pop = w_en;

    // q = round(a / b) in Q30
    assign w_n1 = (N1W'(i_head_a) << QB) + N1W'(i_head_b >> 1);

    atan_div #(.NW(N1W), .DW(OW), .QW(RW), .SBW(FW)) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_head_valid),
        .i_num   (w_n1),
        .i_den   (i_head_b),
        .i_sb    (i_head_flags),
        .o_valid (w_v1),
        .o_quot  (w_q1),
        .o_sb    (w_sb1)
    );

    always_comb begin
        w_prod_sq = (2*RW)'(w_q1) * (2*RW)'(w_q1);
        w_k       = (r_f2.method == METHOD_CUBIC) ? K_CUBIC_A : K_RATIO;
        w_prod_k  = (2*RW)'(w_k) * (2*RW)'(r_sq);
        w_t       = RW'(K_CUBIC_B) - r_m2;
        w_prod_p  = (2*RW)'(w_t) * (2*RW)'(r_q3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= w_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (w_en) begin
            // q squared
            r_q2 <= w_q1;
            r_f2 <= t_flags'(w_sb1);
            r_sq <= RW'((w_prod_sq + (2*RW)'(Q_ONE >> 1)) >> QB);
            // constant times q squared
            r_q3 <= r_q2;
            r_f3 <= r_f2;
            r_m2 <= RW'((w_prod_k + (2*RW)'(Q_ONE >> 1)) >> QB);
            // cubic product, rational denominator
            r_q4 <= r_q3;
            r_f4 <= r_f3;
            r_p  <= RW'((w_prod_p + (2*RW)'(Q_ONE >> 1)) >> QB);
            r_den <= (r_f3.method == METHOD_CUBIC) ? RW'(Q_ONE) : (RW'(Q_ONE) + r_m2);
        end
    end

    // f = round(q / (1 + 0.28 q^2)); cubic items ride along unused
    assign w_n2 = (N2W'(r_q4) << QB) + N2W'(r_den >> 1);

    atan_div #(.NW(N2W), .DW(RW), .QW(RW), .SBW(FW + RW)) u_div_rat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_num   (w_n2),
        .i_den   (r_den),
        .i_sb    ({r_f4, r_p}),
        .o_valid (w_vd),
        .o_quot  (w_f),
        .o_sb    (w_sbd)
    );

    always_comb begin
        w_fd   = t_flags'(w_sbd[FW+RW-1:RW]);
        w_pd   = w_sbd[RW-1:0];
        w_base = w_fd.base_hi ? $signed(AW'(THREE_QTR_PI_Q)) : $signed(AW'(QTR_PI_Q));
        w_fs   = $signed(AW'(w_f));
        if (w_fd.yneg != w_fd.xneg) w_fs = -w_fs;

        if (w_fd.method == METHOD_CUBIC) begin
            w_ang = w_fd.rneg ? (w_base + $signed(AW'(w_pd))) : (w_base - $signed(AW'(w_pd)));
            if (w_fd.yneg) w_ang = -w_ang;
        end else if (w_fd.xzero) begin
            if (w_fd.yneg)       w_ang = -$signed(AW'(HALF_PI_Q));
            else if (w_fd.yzero) w_ang = '0;
            else                 w_ang = $signed(AW'(HALF_PI_Q));
        end else if (!w_fd.swap) begin
            if (!w_fd.xneg)     w_ang = w_fs;
            else if (w_fd.yneg) w_ang = w_fs - $signed(AW'(PI_Q));
            else                w_ang = w_fs + $signed(AW'(PI_Q));
        end else begin
            w_ang = $signed(AW'(HALF_PI_Q)) - w_fs;
            if (w_fd.yneg) w_ang = w_ang - $signed(AW'(PI_Q));
        end

        // round half away from zero on the magnitude
        w_mag = r_ang[AW-1] ? AW'(unsigned'(-r_ang)) : AW'(unsigned'(r_ang));
        w_rnd = (w_mag + HALF) >> S;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v5 <= w_vd;
            r_ov <= r_v5;
        end
        if (w_en) begin
            r_ang <= w_ang;
            r_out <= r_ang[AW-1] ? PW'(-w_rnd) : PW'(w_rnd);
        end
    end

    assign o_valid = r_ov;
    assign o_phase = r_out;

endmodule

FILE: tb/sv/atan2_phase_approximation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_phase_approximation_checker
// Watches the sample and phase channels, predicts each phase from the
// accepted sample and the current method, and compares in order.
// ----------------------------------------------------------------------------
module atan2_phase_approximation_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atan_in_if.sink     i_in,
    atan_out_if.sink    i_out,
    input  logic        i_method,
    output int          o_failures,
    output int          o_pending
);
    import atan_pkg::*;

    localparam longint ONE = 64'd1 << 30;

    logic [15:0] phase_due[$];

    initial o_pending = 0;

    function automatic longint unsigned div_rnd(longint unsigned n, longint unsigned d);
        return (n + d / 2) / d;
    endfunction

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        return (a * b + (ONE >> 1)) >> 30;
    endfunction

    function automatic longint unsigned ratio_of(longint unsigned a, longint unsigned b);
        longint unsigned q, den;
        q   = div_rnd(a << 30, b);
        den = ONE + qmul(longint'(K_RATIO), qmul(q, q));
        return div_rnd(q << 30, den);
    endfunction

    function automatic longint cubic_phase(longint y, longint x);
        longint ay, num, den, base, ang;
        longint unsigned rm, t, p;
        logic rn;
        ay = (y < 0) ? -y : y;
        if (x < 0) begin
            num = x + ay; den = ay - x; base = longint'(THREE_QTR_PI_Q);
        end else begin
            num = x - ay; den = x + ay; base = longint'(QTR_PI_Q);
        end
        if (den == 0) begin
            rm = ONE; rn = 1'b1;
        end else begin
            rm = div_rnd(((num < 0) ? -num : num) << 30, den);
            rn = num < 0;
        end
        t   = longint'(K_CUBIC_B) - qmul(longint'(K_CUBIC_A), qmul(rm, rm));
        p   = qmul(t, rm);
        ang = rn ? base + longint'(p) : base - longint'(p);
        return (y < 0) ? -ang : ang;
    endfunction

    function automatic longint rational_phase(longint y, longint x);
        longint ay, ax, f, pi_v, hp;
        ay = (y < 0) ? -y : y;
        ax = (x < 0) ? -x : x;
        pi_v = longint'(PI_Q);
        hp   = longint'(HALF_PI_Q);
        if (x == 0) return (y > 0) ? hp : (y == 0) ? 0 : -hp;
        if (ay < ax) begin
            f = ratio_of(ay, ax);
            if ((y < 0) != (x < 0)) f = -f;
            if (x < 0) return (y < 0) ? f - pi_v : f + pi_v;
            return f;
        end
        f = ratio_of(ax, ay);
        if ((y < 0) != (x < 0)) f = -f;
        f = hp - f;
        return (y < 0) ? f - pi_v : f;
    endfunction

    function automatic logic [15:0] phase_of(logic [15:0] yv, logic [15:0] xv, logic m);
        longint a, mg;
        a  = m ? rational_phase(longint'($signed(yv)), longint'($signed(xv)))
               : cubic_phase(longint'($signed(yv)), longint'($signed(xv)));
        mg = (((a < 0) ? -a : a) + (64'd1 << 16)) >>> 17;
        return (a < 0) ? 16'(-mg) : 16'(mg);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_failures <= 0;
        end else begin
            if (i_in.valid && i_in.ready)
                phase_due.push_back(phase_of(i_in.y_value, i_in.x_value, i_method));
            if (i_out.valid && i_out.ready) begin
                if (phase_due.size() == 0) begin
                    o_failures <= o_failures + 1;
                    if (o_failures < 10)
                        $display("unexpected phase beat %0d", $signed(i_out.phase_angle));
                end else begin
                    if (phase_due[0] !== i_out.phase_angle) begin
                        o_failures <= o_failures + 1;
                        if (o_failures < 10)
                            $display("phase mismatch: expected %0d got %0d",
                                     $signed(phase_due[0]), $signed(i_out.phase_angle));
                    end
                    void'(phase_due.pop_front());
                end
            end
        end
        o_pending <= phase_due.size();
    end
endmodule

FILE: tb/sv/atan2_phase_approximation_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_phase_approximation_top_test
// Drives samples and method writes into the phase block; the checker does
// prediction and comparison, this module gives the verdict.
// ----------------------------------------------------------------------------
module atan2_phase_approximation_top_test;
    import atan_pkg::*;

    localparam int LATENCY  = 68;
    localparam int WDOG_MAX = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        method = 1'b1;   // mirror of the method register
    logic        quiet = 1'b0;    // last stretch: no idling on either side
    int          failures, pending, beats, wdog;

    atan_in_if  #(.SW(16)) smp ();
    atan_out_if #(.PW(16)) phs ();

    always #4 i_clk = ~i_clk;

    atan2_phase_approximation_top dut (
        .i_clk, .i_rst_n, .i_in(smp), .o_out(phs),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    atan2_phase_approximation_checker chk (
        .i_clk, .i_rst_n, .i_in(smp), .i_out(phs), .i_method(method),
        .o_failures(failures), .o_pending(pending)
    );

    initial begin
        smp.valid = 1'b0; smp.y_value = '0; smp.x_value = '0;
        phs.ready = 1'b0;
    end

    // Receiver stalls in random bursts, none in the quiet stretch.
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n || quiet) begin
            phs.ready <= 1'b1;
        end else if ($urandom_range(0, 15) == 0) begin
            n = $urandom_range(1, 14);
            phs.ready <= 1'b0;
            repeat (n) @(posedge i_clk);
            phs.ready <= 1'b1;
        end else begin
            phs.ready <= 1'b1;
        end
    end

    // Watchdog: cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (phs.valid && phs.ready)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog > WDOG_MAX) begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_sample(logic [15:0] yv, logic [15:0] xv);
        int n;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 14);
            smp.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        smp.valid <= 1'b1; smp.y_value <= yv; smp.x_value <= xv;
        do @(posedge i_clk); while (!smp.ready);
        beats++;
    endtask

    task automatic drain();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // APB write of the method bit, with random data in the upper bits.
    task automatic write_method(logic m);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {REG_METHOD_SELECT, 2'b00}; pwdata <= {$urandom() & ~32'h1} | m;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        method <= m;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random sample: full range in a third of cases, else near axes, diagonals, extremes.
    task automatic random_sample();
        logic [15:0] yv, xv;
        case ($urandom_range(0, 5))
            0: begin yv = 16'($urandom_range(0, 6) - 3); xv = 16'($urandom()); end
            1: begin xv = 16'($urandom_range(0, 6) - 3); yv = 16'($urandom()); end
            2: begin yv = 16'($urandom()); xv = ($urandom_range(0, 1)) ? yv : -yv; end
            3: begin yv = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff; xv = 16'($urandom()); end
            default: begin yv = 16'($urandom()); xv = 16'($urandom()); end
        endcase
        send_sample(yv, xv);
    endtask

    logic [15:0] edge_v[7] = '{16'h8000, 16'h8001, 16'hffff, 16'h0000,
                              16'h0001, 16'h7ffe, 16'h7fff};

    initial begin
        beats = 0; wdog = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: axes, origin, extremes and diagonals under both methods.
        for (int m = 1; m >= 0; m--) begin
            if (m == 0) write_method(METHOD_CUBIC);
            for (int k = 0; k < 7; k++) send_sample(edge_v[k], 16'h0000);
            for (int k = 0; k < 7; k++) send_sample(16'h0000, edge_v[k]);
            for (int k = 0; k < 7; k++) send_sample(edge_v[k], edge_v[6 - k]);
            send_sample(16'h7fff, 16'h7fff);
            send_sample(16'h8000, 16'h8000);
            drain();
        end

        // Random phases, alternating method; pauses drain the pipeline.
        for (int ph = 0; ph < 6; ph++) begin
            write_method(ph[0] ? METHOD_RATIONAL : METHOD_CUBIC);
            if (ph == 5) quiet = 1'b1;
            repeat (200) random_sample();
            drain();
        end
        write_method(METHOD_RATIONAL);

        $display("covered %0d samples over both methods: axes, origin, extremes, diagonals",
                 beats);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: files.f
sv/atan_pkg.sv
sv/atan_if.sv
sv/atan_front.sv
sv/atan_div.sv
sv/atan_back.sv
sv/atan2_phase_approximation_top.sv
tb/sv/atan2_phase_approximation_checker.sv
tb/sv/atan2_phase_approximation_top_test.sv
